### rtl/core/okoe_pkg.sv
`default_nettype none

package okoe_pkg;

	// field widths
	localparam int N_W         = 4;
	localparam int TADDR_W     = 6;
	localparam int WEIGHT_W    = 16;
	localparam int OCT_W       = 3;
	localparam int IDX_W       = 9;
	localparam int ELEM_W      = 32;
	localparam int S_TDATA_W   = 48;
	localparam int M_TDATA_W   = 32;

	// defaults
	localparam int          DEFAULT_MAX_NODES = 8;
	localparam logic [3:0]  NODES_RESET       = 4'd4;
	localparam int          OUT_FIFO_DEPTH    = 16;

	// digit split by reciprocal multiply
	localparam int RECIP_W     = 15;
	localparam int RECIP_SHIFT = 14;
	localparam int CUBE_W      = 12;

	// product and rounding
	localparam int PAIR_W      = 2 * WEIGHT_W;
	localparam int PROD_W      = 3 * WEIGHT_W;
	localparam int ROUND_SHIFT = 14;

	// request kinds carried in tuser
	localparam logic OPC_LOAD  = 1'b0;
	localparam logic OPC_QUERY = 1'b1;

	typedef logic signed [WEIGHT_W-1:0] weight_t;
	typedef logic [N_W-1:0]             digit_t;

	// ceil(2^14 / n), exact quotient for dividends below 512
	function automatic logic [RECIP_W-1:0] recip_of(input logic [N_W-1:0] n);
		logic [RECIP_W-1:0] r;
		unique case (n)
			4'd0:  r = 15'd0;
			4'd1:  r = 15'd16384;
			4'd2:  r = 15'd8192;
			4'd3:  r = 15'd5462;
			4'd4:  r = 15'd4096;
			4'd5:  r = 15'd3277;
			4'd6:  r = 15'd2731;
			4'd7:  r = 15'd2341;
			4'd8:  r = 15'd2048;
			4'd9:  r = 15'd1821;
			4'd10: r = 15'd1639;
			4'd11: r = 15'd1490;
			4'd12: r = 15'd1366;
			4'd13: r = 15'd1261;
			4'd14: r = 15'd1171;
			4'd15: r = 15'd1093;
			default: r = 15'd0;
		endcase
		return r;
	endfunction

	// n cubed
	function automatic logic [CUBE_W-1:0] cube_of(input logic [N_W-1:0] n);
		logic [CUBE_W-1:0] c;
		unique case (n)
			4'd0:  c = 12'd0;
			4'd1:  c = 12'd1;
			4'd2:  c = 12'd8;
			4'd3:  c = 12'd27;
			4'd4:  c = 12'd64;
			4'd5:  c = 12'd125;
			4'd6:  c = 12'd216;
			4'd7:  c = 12'd343;
			4'd8:  c = 12'd512;
			4'd9:  c = 12'd729;
			4'd10: c = 12'd1000;
			4'd11: c = 12'd1331;
			4'd12: c = 12'd1728;
			4'd13: c = 12'd2197;
			4'd14: c = 12'd2744;
			4'd15: c = 12'd3375;
			default: c = 12'd0;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

### rtl/core/okoe_wmem.sv
`default_nettype none

module okoe_wmem #(
	parameter int DEPTH    = okoe_pkg::DEFAULT_MAX_NODES * okoe_pkg::DEFAULT_MAX_NODES,
	parameter int RD_PORTS = 1
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [$clog2(DEPTH)-1:0]               waddr,
	input  wire okoe_pkg::weight_t                      wdata,
	input  wire logic [RD_PORTS-1:0][$clog2(DEPTH)-1:0] raddr,
	output okoe_pkg::weight_t [RD_PORTS-1:0]            rdata
);

	okoe_pkg::weight_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read ports
	always_ff @(posedge clk) begin
		for (int i = 0; i < RD_PORTS; i++) begin
			rdata[i] <= mem[raddr[i]];
		end
	end

endmodule

`default_nettype wire

### rtl/core/okoe_fifo.sv
`default_nettype none

module okoe_fifo #(
	parameter int W     = okoe_pkg::ELEM_W + 1,
	parameter int DEPTH = okoe_pkg::OUT_FIFO_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	input  wire logic         pop,
	output logic              out_valid,
	output logic [W-1:0]      out_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign out_valid = (count_q != '0);
	assign out_data  = slot_q[rd_ptr_q];

	// push only into free space, pop only when holding a result
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != CNT_W'(DEPTH)) || pop)
		else $error("result fifo overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("result fifo underflow");

endmodule

`default_nettype wire

### rtl/core/octant_kronecker_operator_element_unit.sv
`default_nettype none

// Octant transfer operator element unit.
// Input stream (s_*): each request is a weight load (s_tuser = 0) or an element
// query (s_tuser = 1). A load writes one entry of the n-by-n weight table and
// returns nothing; a query returns one result on the output stream (m_*) with
// the Q3.28 element in m_tdata and the index error flag in m_tuser.
// Configuration: cfg_we with cfg_wdata sets n (nodes per dimension), clamped
// to MAX_NODES; write it only while no request is in flight.
// A query passes through the pipeline stages and then into the result queue,
// which raises m_tvalid. Throughput is one request per cycle while s_tready
// is high; the seven-stage pipeline (digit split, table read, two multiplies,
// rounding) never stalls. The x and y weights come from the two read ports of
// one copy of the table and the z weight from a second copy, so all three
// weights arrive together.
// Results collect in a 16-entry queue; s_tready drops only when every queue
// slot is claimed by queries in flight or waiting, so a stalled receiver
// fills the queue and then holds off new requests.
// Reset: n returns to 4 (or MAX_NODES if smaller), the pipeline and queue
// empty. The weight table is not cleared; load every entry before use.

module octant_kronecker_operator_element_unit #(
	parameter int MAX_NODES = okoe_pkg::DEFAULT_MAX_NODES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// config: n, nodes per dimension
	input  wire logic        cfg_we,
	input  wire logic [3:0]  cfg_wdata,
	// request stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [5:0] table_address, [21:6] table_value, [24:22] child_octant,
	// [33:25] row_index, [42:34] col_index, [47:43] zero
	input  wire logic [47:0] s_tdata,
	// [0] opcode
	input  wire logic        s_tuser,
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [31:0] element_value
	output logic [31:0]      m_tdata,
	// [0] index_error
	output logic             m_tuser
);

	localparam int TABLE_DEPTH = MAX_NODES * MAX_NODES;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int N_W         = okoe_pkg::N_W;
	localparam int IDX_W       = okoe_pkg::IDX_W;
	localparam int FDEPTH      = okoe_pkg::OUT_FIFO_DEPTH;
	localparam int RES_W       = $clog2(FDEPTH + 1);
	localparam logic [N_W-1:0] N_RESET =
		(int'(okoe_pkg::NODES_RESET) > MAX_NODES) ? N_W'(MAX_NODES) : okoe_pkg::NODES_RESET;

	// configuration, clamped on write
	logic [N_W-1:0] n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= N_RESET;
		end else if (cfg_we) begin
			n_q <= (int'(cfg_wdata) > MAX_NODES) ? N_W'(MAX_NODES) : cfg_wdata;
		end
	end

	logic [okoe_pkg::RECIP_W-1:0] recip;
	logic [okoe_pkg::CUBE_W-1:0]  cube;

	assign recip = okoe_pkg::recip_of(n_q);
	assign cube  = okoe_pkg::cube_of(n_q);

	// input handshake and result slot reservation
	logic             s_acc;
	logic             m_acc;
	logic             query_acc;
	logic [RES_W-1:0] reserved_q;

	assign s_acc     = s_tvalid && s_tready;
	assign m_acc     = m_tvalid && m_tready;
	assign query_acc = s_acc && (s_tuser == okoe_pkg::OPC_QUERY);
	assign s_tready  = (reserved_q < RES_W'(FDEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_q <= '0;
		end else if (query_acc && !m_acc) begin
			reserved_q <= reserved_q + 1'b1;
		end else if (m_acc && !query_acc) begin
			reserved_q <= reserved_q - 1'b1;
		end
	end

	// stage valid and kind bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic op_s1, op_s2, op_s3, op_s4, op_s5, op_s6, op_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= s_acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// stage 1: request capture
	logic [okoe_pkg::TADDR_W-1:0] taddr_s1, taddr_s2, taddr_s3, taddr_s4;
	okoe_pkg::weight_t            tval_s1, tval_s2, tval_s3, tval_s4;
	logic [okoe_pkg::OCT_W-1:0]   oct_s1, oct_s2, oct_s3, oct_s4;
	logic [IDX_W-1:0]             row_s1, col_s1, row_s2, col_s2;

	always_ff @(posedge clk) begin
		op_s1    <= s_tuser;
		taddr_s1 <= s_tdata[5:0];
		tval_s1  <= s_tdata[21:6];
		oct_s1   <= s_tdata[24:22];
		row_s1   <= s_tdata[33:25];
		col_s1   <= s_tdata[42:34];
	end

	// stage 1 -> 2: range check and first quotient by reciprocal
	localparam int PQ_W = IDX_W + okoe_pkg::RECIP_W;

	logic [PQ_W-1:0]  prow, pcol;
	logic             err_s2, err_s3, err_s4, err_s5, err_s6, err_s7;
	logic [IDX_W-1:0] qr_s2, qc_s2;

	assign prow = row_s1 * recip;
	assign pcol = col_s1 * recip;

	always_ff @(posedge clk) begin
		op_s2    <= op_s1;
		taddr_s2 <= taddr_s1;
		tval_s2  <= tval_s1;
		oct_s2   <= oct_s1;
		row_s2   <= row_s1;
		col_s2   <= col_s1;
		err_s2   <= (okoe_pkg::CUBE_W'(row_s1) >= cube) ||
		            (okoe_pkg::CUBE_W'(col_s1) >= cube);
		qr_s2    <= prow[okoe_pkg::RECIP_SHIFT +: IDX_W];
		qc_s2    <= pcol[okoe_pkg::RECIP_SHIFT +: IDX_W];
	end

	// stage 2 -> 3: z digits and second quotient
	logic [IDX_W+N_W-1:0] qnr, qnc;
	logic [IDX_W-1:0]     remr, remc;
	logic [PQ_W-1:0]      pqr, pqc;
	okoe_pkg::digit_t     zr_s3, zc_s3, zr_s4, zc_s4;
	logic [IDX_W-1:0]     qr_s3, qc_s3, q2r_s3, q2c_s3;

	assign qnr  = qr_s2 * n_q;
	assign qnc  = qc_s2 * n_q;
	assign remr = row_s2 - qnr[IDX_W-1:0];
	assign remc = col_s2 - qnc[IDX_W-1:0];
	assign pqr  = qr_s2 * recip;
	assign pqc  = qc_s2 * recip;

	always_ff @(posedge clk) begin
		op_s3    <= op_s2;
		taddr_s3 <= taddr_s2;
		tval_s3  <= tval_s2;
		oct_s3   <= oct_s2;
		err_s3   <= err_s2;
		zr_s3    <= remr[N_W-1:0];
		zc_s3    <= remc[N_W-1:0];
		qr_s3    <= qr_s2;
		qc_s3    <= qc_s2;
		q2r_s3   <= pqr[okoe_pkg::RECIP_SHIFT +: IDX_W];
		q2c_s3   <= pqc[okoe_pkg::RECIP_SHIFT +: IDX_W];
	end

	// stage 3 -> 4: y and x digits
	logic [IDX_W+N_W-1:0] q2nr, q2nc;
	logic [IDX_W-1:0]     yremr, yremc;
	okoe_pkg::digit_t     xr_s4, xc_s4, yr_s4, yc_s4;

	assign q2nr  = q2r_s3 * n_q;
	assign q2nc  = q2c_s3 * n_q;
	assign yremr = qr_s3 - q2nr[IDX_W-1:0];
	assign yremc = qc_s3 - q2nc[IDX_W-1:0];

	always_ff @(posedge clk) begin
		op_s4    <= op_s3;
		taddr_s4 <= taddr_s3;
		tval_s4  <= tval_s3;
		oct_s4   <= oct_s3;
		err_s4   <= err_s3;
		zr_s4    <= zr_s3;
		zc_s4    <= zc_s3;
		yr_s4    <= yremr[N_W-1:0];
		yc_s4    <= yremc[N_W-1:0];
		xr_s4    <= q2r_s3[N_W-1:0];
		xc_s4    <= q2c_s3[N_W-1:0];
	end

	// stage 4: mirrored table addresses, table write for loads
	function automatic logic [ADDR_W-1:0] tab_addr(
		input logic [N_W-1:0] n,
		input logic [N_W-1:0] a,
		input logic [N_W-1:0] b,
		input logic           mirror
	);
		logic [N_W-1:0]   am, bm;
		logic [2*N_W-1:0] lin;
		am  = mirror ? (n - 1'b1 - a) : a;
		bm  = mirror ? (n - 1'b1 - b) : b;
		lin = am * n + (2*N_W)'(bm);
		return lin[ADDR_W-1:0];
	endfunction

	logic [ADDR_W-1:0]      raddr_x, raddr_y, raddr_z;
	logic [1:0][ADDR_W-1:0] raddr_xy;
	logic                   wr_en;
	logic [ADDR_W-1:0]      waddr;

	assign raddr_x  = tab_addr(n_q, xr_s4, xc_s4, oct_s4[2]);
	assign raddr_y  = tab_addr(n_q, yr_s4, yc_s4, oct_s4[1]);
	assign raddr_z  = tab_addr(n_q, zr_s4, zc_s4, oct_s4[0]);
	assign raddr_xy = {raddr_y, raddr_x};
	assign wr_en    = v_s4 && (op_s4 == okoe_pkg::OPC_LOAD) &&
	                  (int'(taddr_s4) < TABLE_DEPTH);
	assign waddr    = ADDR_W'(taddr_s4);

	okoe_pkg::weight_t [1:0] wxy_s5;
	okoe_pkg::weight_t       wx_s5, wy_s5, wz_s5;

	// x and y weights from one copy with two read ports
	okoe_wmem #(.DEPTH(TABLE_DEPTH), .RD_PORTS(2)) u_wmem_xy (
		.clk   (clk),
		.we    (wr_en),
		.waddr (waddr),
		.wdata (tval_s4),
		.raddr (raddr_xy),
		.rdata (wxy_s5)
	);

	// z weight from the second copy
	okoe_wmem #(.DEPTH(TABLE_DEPTH), .RD_PORTS(1)) u_wmem_z (
		.clk   (clk),
		.we    (wr_en),
		.waddr (waddr),
		.wdata (tval_s4),
		.raddr (raddr_z),
		.rdata (wz_s5)
	);

	assign wx_s5 = wxy_s5[0];
	assign wy_s5 = wxy_s5[1];

	always_ff @(posedge clk) begin
		op_s5  <= op_s4;
		err_s5 <= err_s4;
	end

	// stage 5 -> 6: x times y
	logic signed [okoe_pkg::PAIR_W-1:0] pxy, pxy_s6;
	okoe_pkg::weight_t                  wz_s6;

	assign pxy = wx_s5 * wy_s5;

	always_ff @(posedge clk) begin
		op_s6  <= op_s5;
		err_s6 <= err_s5;
		pxy_s6 <= pxy;
		wz_s6  <= wz_s5;
	end

	// stage 6 -> 7: times z, exact Q3.42
	logic signed [okoe_pkg::PROD_W-1:0] pxyz, pxyz_s7;

	assign pxyz = pxy_s6 * wz_s6;

	always_ff @(posedge clk) begin
		op_s7   <= op_s6;
		err_s7  <= err_s6;
		pxyz_s7 <= pxyz;
	end

	// stage 7: round half up to Q3.28, zero on index error, into result queue
	localparam logic signed [okoe_pkg::PROD_W-1:0] HALF_LSB =
		okoe_pkg::PROD_W'(1) << (okoe_pkg::ROUND_SHIFT - 1);

	logic signed [okoe_pkg::PROD_W-1:0] biased;
	logic [okoe_pkg::ELEM_W-1:0]        elem;
	logic                               push;

	assign biased = pxyz_s7 + HALF_LSB;
	assign elem   = err_s7 ? '0 : biased[okoe_pkg::ROUND_SHIFT +: okoe_pkg::ELEM_W];
	assign push   = v_s7 && (op_s7 == okoe_pkg::OPC_QUERY);

	okoe_fifo #(
		.W     (okoe_pkg::ELEM_W + 1),
		.DEPTH (FDEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({err_s7, elem}),
		.pop       (m_acc),
		.out_valid (m_tvalid),
		.out_data  ({m_tuser, m_tdata})
	);

	// slot reservations never exceed the queue
	a_reserve_bound: assert property (@(posedge clk) disable iff (!arst_n)
		reserved_q <= RES_W'(FDEPTH))
		else $error("result reservations exceed queue depth");

	// every query reaches the queue a fixed number of stages later
	a_query_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && (op_s1 == okoe_pkg::OPC_QUERY)) |-> ##6 push)
		else $error("query lost in pipeline");

	// a result is only offered while a reservation backs it
	a_result_reserved: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (reserved_q != '0))
		else $error("result without reservation");

endmodule

`default_nettype wire

### tb/sv/octant_kronecker_operator_element_unit_tb.sv
`timescale 1ns / 100ps

module octant_kronecker_operator_element_unit_tb;

	localparam int TABLE_DEPTH   = 64;
	localparam int MAX_N         = 8;
	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 12;

	typedef struct packed {
		logic [okoe_pkg::ELEM_W-1:0] element_value;
		logic                        index_error;
	} element_result_t;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           cfg_we    = 1'b0;
	logic [okoe_pkg::N_W-1:0]       cfg_wdata = '0;
	logic                           s_tvalid  = 1'b0;
	logic                           s_tready;
	logic [okoe_pkg::S_TDATA_W-1:0] s_tdata   = '0;
	logic                           s_tuser   = okoe_pkg::OPC_LOAD;
	logic                           m_tvalid;
	logic                           m_tready  = 1'b0;
	logic [okoe_pkg::M_TDATA_W-1:0] m_tdata;
	logic                           m_tuser;

	// shadow of the weight table and of n, updated as requests are accepted
	okoe_pkg::weight_t        weight_shadow [TABLE_DEPTH];
	logic [okoe_pkg::N_W-1:0] nodes_setting = okoe_pkg::NODES_RESET;
	element_result_t          pending_elements[$];
	int                       error_count    = 0;
	int                       idle_cycles    = 0;
	int                       send_gap_pct   = 0;
	int                       recv_stall_pct = 0;

	octant_kronecker_operator_element_unit #(
		.MAX_NODES(MAX_N)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("%0t ns: %s", $time, msg);
	endtask

	// product of three mirrored weights, rounded half up to Q3.28
	function automatic element_result_t predict_element(
			input logic [okoe_pkg::OCT_W-1:0] octant,
			input logic [okoe_pkg::IDX_W-1:0] row, input logic [okoe_pkg::IDX_W-1:0] col);
		int unsigned     n;
		int unsigned     n3;
		int unsigned     row_digit [3];
		int unsigned     col_digit [3];
		int unsigned     a;
		int unsigned     b;
		int              axis;
		longint          product;
		element_result_t res;
		n   = (nodes_setting > MAX_N) ? MAX_N : nodes_setting;
		n3  = n * n * n;
		res = '0;
		if (row >= n3 || col >= n3) begin
			res.index_error = 1'b1;
			return res;
		end
		// digits x, y, z
		row_digit[0] = row / (n * n);
		row_digit[1] = (row / n) % n;
		row_digit[2] = row % n;
		col_digit[0] = col / (n * n);
		col_digit[1] = (col / n) % n;
		col_digit[2] = col % n;
		product = 1;
		for (axis = 0; axis < 3; axis++) begin
			a = row_digit[axis];
			b = col_digit[axis];
			if (octant[2 - axis]) begin
				a = n - 1 - a;
				b = n - 1 - b;
			end
			product = product * longint'(weight_shadow[a * n + b]);
		end
		res.element_value = 32'((product + 64'sd8192) >>> 14);
		return res;
	endfunction

	// one request on the input stream, with an occasional gap before it
	task automatic send_request(input logic opcode,
			input logic [okoe_pkg::TADDR_W-1:0] addr,
			input okoe_pkg::weight_t value, input logic [okoe_pkg::OCT_W-1:0] octant,
			input logic [okoe_pkg::IDX_W-1:0] row, input logic [okoe_pkg::IDX_W-1:0] col);
		if ($urandom_range(0, 99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= opcode;
		s_tdata  <= {5'b0, col, row, octant, value, addr};
		do @(posedge clk); while (!s_tready);
		if (opcode == okoe_pkg::OPC_LOAD)
			weight_shadow[addr] = value;
		else
			pending_elements = {pending_elements, predict_element(octant, row, col)};
	endtask

	// unused fields carry random noise
	task automatic send_load(input logic [okoe_pkg::TADDR_W-1:0] addr,
			input okoe_pkg::weight_t value);
		send_request(okoe_pkg::OPC_LOAD, addr, value, okoe_pkg::OCT_W'($urandom),
			okoe_pkg::IDX_W'($urandom), okoe_pkg::IDX_W'($urandom));
	endtask

	task automatic send_query(input logic [okoe_pkg::OCT_W-1:0] octant,
			input logic [okoe_pkg::IDX_W-1:0] row, input logic [okoe_pkg::IDX_W-1:0] col);
		send_request(okoe_pkg::OPC_QUERY, okoe_pkg::TADDR_W'($urandom),
			okoe_pkg::WEIGHT_W'($urandom), octant, row, col);
	endtask

	task automatic send_random_load(input logic [okoe_pkg::TADDR_W-1:0] addr);
		okoe_pkg::weight_t value;
		value = okoe_pkg::WEIGHT_W'($urandom);
		if ($urandom_range(0, 9) == 0)
			value = 16'sh8000;
		else if ($urandom_range(0, 9) == 0)
			value = 16'sh7fff;
		send_load(addr, value);
	endtask

	// mostly in-range indexes, some anywhere in the 9-bit range
	task automatic send_random_query();
		int unsigned                n;
		int unsigned                n3;
		logic [okoe_pkg::IDX_W-1:0] row;
		logic [okoe_pkg::IDX_W-1:0] col;
		n   = (nodes_setting > MAX_N) ? MAX_N : nodes_setting;
		n3  = n * n * n;
		row = okoe_pkg::IDX_W'($urandom);
		col = okoe_pkg::IDX_W'($urandom);
		if (n3 != 0 && $urandom_range(0, 9) != 0)
			row = okoe_pkg::IDX_W'($urandom_range(0, n3 - 1));
		if (n3 != 0 && $urandom_range(0, 9) != 0)
			col = okoe_pkg::IDX_W'($urandom_range(0, n3 - 1));
		send_query(okoe_pkg::OCT_W'($urandom), row, col);
	endtask

	task automatic run_random_mix(input int count);
		repeat (count) begin
			if ($urandom_range(0, 99) < 30)
				send_random_load(okoe_pkg::TADDR_W'($urandom_range(0, TABLE_DEPTH - 1)));
			else
				send_random_query();
		end
	endtask

	// hold off requests until every result is back, then let the pipe settle
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_elements.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_nodes(input logic [okoe_pkg::N_W-1:0] n);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= n;
		@(posedge clk);
		cfg_we <= 1'b0;
		nodes_setting = n;
	endtask

	// n = 4 after reset: weight extremes, mirroring, rounding tie, bad indexes
	task automatic test_directed_extremes();
		int                addr;
		okoe_pkg::weight_t value;
		for (addr = 0; addr < 16; addr++) begin
			value = okoe_pkg::WEIGHT_W'($urandom);
			case (addr)
				0:       value = 16'sh7fff;
				1:       value = 16'sh8000;
				5:       value = 16'sd1;
				6:       value = 16'sd8192;
				7:       value = -16'sd8192;
				default: ;
			endcase
			send_load(okoe_pkg::TADDR_W'(addr), value);
		end
		send_query(3'd0, 9'd0, 9'd0);
		send_query(3'd0, 9'd0, 9'd21);
		send_query(3'd7, 9'd0, 9'd21);
		send_query(3'd7, 9'd63, 9'd63);
		send_query(3'd0, 9'd21, 9'd22);
		send_query(3'd0, 9'd21, 9'd23);
		send_query(3'd2, 9'd63, 9'd0);
		send_query(3'd5, 9'd37, 9'd42);
		send_query(3'd0, 9'd64, 9'd0);
		send_query(3'd0, 9'd0, 9'd64);
		send_query(3'd7, 9'd511, 9'd511);
	endtask

	// write the rest of the table, with queries in between
	task automatic test_table_fill();
		int addr;
		for (addr = 16; addr < TABLE_DEPTH; addr++) begin
			send_random_load(okoe_pkg::TADDR_W'(addr));
			send_random_query();
		end
	endtask

	task automatic test_node_size(input logic [okoe_pkg::N_W-1:0] n, input int count);
		write_nodes(n);
		run_random_mix(count);
	endtask

	// result checker and receiver stalls
	always @(posedge clk) begin
		element_result_t want;
		if (m_tvalid && m_tready) begin
			if (pending_elements.size() == 0) begin
				report_mismatch($sformatf("result %h err %b with no query waiting",
					m_tdata, m_tuser));
			end else begin
				want = pending_elements.pop_front();
				if (m_tdata !== want.element_value)
					report_mismatch($sformatf("element_value got %h expected %h",
						m_tdata, want.element_value));
				if (m_tuser !== want.index_error)
					report_mismatch($sformatf("index_error got %b expected %b",
						m_tuser, want.index_error));
			end
		end
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// watchdog on cycles with no request or result moving
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		send_gap_pct   = 38;
		recv_stall_pct = 66;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		test_table_fill();
		test_node_size(4'd1, 60);
		test_node_size(4'd8, 80);
		// above the table size, clamps to 8
		test_node_size(4'd15, 60);
		send_gap_pct   = 66;
		recv_stall_pct = 38;
		// every query is out of range
		test_node_size(4'd0, 30);
		test_node_size(4'd2, 60);
		test_node_size(4'd3, 60);
		send_gap_pct   = 0;
		recv_stall_pct = 0;
		test_node_size(4'd5, 60);
		test_node_size(4'd6, 60);
		test_node_size(4'd7, 60);
		test_node_size(4'd4, 60);
		wait_idle();
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
